// ----- src/chgw_pkg.sv -----
// package for the gift-wrap convex hull block: transaction types, microcode
// op and jump codes, step addresses and the microcode program table
// no dependencies
`timescale 1ns / 1ps

package chgw_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_W        = 16;

    typedef struct packed {
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic                      last_point;
    } point_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] hull_x;
        logic signed [FIELD_W-1:0] hull_y;
        logic                      last_hull_point;
        logic                      points_dropped;
    } hull_item_t;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_IDLE      = 4'd0;
    localparam logic [OP_W-1:0] OP_LM_INIT   = 4'd1;
    localparam logic [OP_W-1:0] OP_READ      = 4'd2;
    localparam logic [OP_W-1:0] OP_LM_CMP    = 4'd3;
    localparam logic [OP_W-1:0] OP_WALK_INIT = 4'd4;
    localparam logic [OP_W-1:0] OP_P_LOAD    = 4'd5;
    localparam logic [OP_W-1:0] OP_Q_LOAD    = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL       = 4'd7;
    localparam logic [OP_W-1:0] OP_S_CMP     = 4'd8;
    localparam logic [OP_W-1:0] OP_EMIT      = 4'd9;
    localparam logic [OP_W-1:0] OP_FINISH    = 4'd10;

    // jump conditions
    localparam int JC_W = 3;
    localparam logic [JC_W-1:0] JC_NEXT      = 3'd0;
    localparam logic [JC_W-1:0] JC_ALWAYS    = 3'd1;
    localparam logic [JC_W-1:0] JC_WAIT_LAST = 3'd2;
    localparam logic [JC_W-1:0] JC_MORE      = 3'd3;
    localparam logic [JC_W-1:0] JC_NOT_TERM  = 3'd4;

    // step addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LM_INIT   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LM_RD     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LM_CMP    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_WALK_INIT = 4'd4;
    localparam logic [STEP_W-1:0] STEP_P_RD      = 4'd5;
    localparam logic [STEP_W-1:0] STEP_P_LOAD    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_Q_RD      = 4'd7;
    localparam logic [STEP_W-1:0] STEP_Q_LOAD    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_S_RD      = 4'd9;
    localparam logic [STEP_W-1:0] STEP_S_MUL     = 4'd10;
    localparam logic [STEP_W-1:0] STEP_S_CMP     = 4'd11;
    localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd12;
    localparam logic [STEP_W-1:0] STEP_FINISH    = 4'd13;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [JC_W-1:0]   cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic start_last;   // last point of a set taken this cycle
        logic more;         // scan index has another point after it
        logic term;         // walk ends with the point now emitted
    } seq_status_t;

    // microcode program
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        unique case (step)
            STEP_IDLE:      w = '{OP_IDLE,      JC_WAIT_LAST, STEP_IDLE};
            STEP_LM_INIT:   w = '{OP_LM_INIT,   JC_NEXT,      STEP_IDLE};
            STEP_LM_RD:     w = '{OP_READ,      JC_NEXT,      STEP_IDLE};
            STEP_LM_CMP:    w = '{OP_LM_CMP,    JC_MORE,      STEP_LM_RD};
            STEP_WALK_INIT: w = '{OP_WALK_INIT, JC_NEXT,      STEP_IDLE};
            STEP_P_RD:      w = '{OP_READ,      JC_NEXT,      STEP_IDLE};
            STEP_P_LOAD:    w = '{OP_P_LOAD,    JC_NEXT,      STEP_IDLE};
            STEP_Q_RD:      w = '{OP_READ,      JC_NEXT,      STEP_IDLE};
            STEP_Q_LOAD:    w = '{OP_Q_LOAD,    JC_NEXT,      STEP_IDLE};
            STEP_S_RD:      w = '{OP_READ,      JC_NEXT,      STEP_IDLE};
            STEP_S_MUL:     w = '{OP_MUL,       JC_NEXT,      STEP_IDLE};
            STEP_S_CMP:     w = '{OP_S_CMP,     JC_MORE,      STEP_S_RD};
            STEP_EMIT:      w = '{OP_EMIT,      JC_NOT_TERM,  STEP_P_RD};
            STEP_FINISH:    w = '{OP_FINISH,    JC_ALWAYS,    STEP_IDLE};
            default:        w = '{OP_FINISH,    JC_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- src/chgw_seq.sv -----
// microcode sequencer: step counter, program table lookup and jump logic
// depends on chgw_pkg
`timescale 1ns / 1ps

module chgw_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  chgw_pkg::seq_status_t status,
    output chgw_pkg::ctrl_word_t  ctrl
);
    import chgw_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] step_inc;

    assign ctrl     = ucode(step_reg);
    assign step_inc = step_reg + 1'b1;

    always_comb
    begin
        unique case (ctrl.cond)
            JC_NEXT:      step_next = step_inc;
            JC_ALWAYS:    step_next = ctrl.target;
            JC_WAIT_LAST: step_next = status.start_last ? step_inc : ctrl.target;
            JC_MORE:      step_next = status.more ? ctrl.target : step_inc;
            JC_NOT_TERM:  step_next = status.term ? step_inc : ctrl.target;
            default:      step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- src/convex_hull_gift_wrap.sv -----
// gift-wrap (jarvis march) convex hull: top level with point store and datapath
// depends on chgw_pkg and chgw_seq
// sequence: a point without last_point is taken and busy stays low; the last point
//   starts the leftmost search (a read and a compare step per stored point), then
//   walk setup, then per hull point: load p and q, scan every stored point, emit;
//   the first result is strobed after the first such pass
// throughput: set by the single read port of the point store, one point per scan
//   pass taking three microcode steps (read, multiply, compare); busy while the walk
//   runs, drops the cycle after the final result; no point is taken while busy
// reset: asynchronous active-low; clears control state, the store itself is not cleared
// results are strobed for one cycle and the receiver cannot stall them
`timescale 1ns / 1ps

module convex_hull_gift_wrap #(
    parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chgw_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  chgw_pkg::point_item_t point,
    output logic                  hull_valid,
    output chgw_pkg::hull_item_t  hull
);
    import chgw_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int DIF_W = COORD_BITS + 1;
    localparam int PRD_W = 2 * DIF_W;

    // wrap a 16 bit input coordinate to the stored width
    function automatic logic [COORD_BITS-1:0] to_coord(input logic [FIELD_W-1:0] v);
        logic [31:0] w;
        w = {{(32 - FIELD_W){v[FIELD_W-1]}}, v};
        return w[COORD_BITS-1:0];
    endfunction

    // stored coordinate back to the 16 bit result field
    function automatic logic [FIELD_W-1:0] to_field(input logic [COORD_BITS-1:0] v);
        logic [31:0] w;
        w = {{(32 - COORD_BITS){v[COORD_BITS-1]}}, v};
        return w[FIELD_W-1:0];
    endfunction

    // sequencer
    ctrl_word_t  ctrl;
    seq_status_t status;

    chgw_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // point store, one write port (loading) and one registered read port
    logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
    logic [COORD_BITS-1:0] mem_y [MAX_POINTS];
    logic signed [COORD_BITS-1:0] rd_x_reg;
    logic signed [COORD_BITS-1:0] rd_y_reg;

    // control registers
    logic [CNT_W-1:0] count_reg,    count_next;
    logic             ovf_reg,      ovf_next;
    logic [IDX_W-1:0] start_reg,    start_next;
    logic [IDX_W-1:0] cur_reg,      cur_next;
    logic [IDX_W-1:0] cand_reg,     cand_next;
    logic [IDX_W-1:0] idx_reg,      idx_next;
    logic [CNT_W-1:0] hull_cnt_reg, hull_cnt_next;
    logic             hull_valid_reg, hull_valid_next;

    // payload registers
    logic signed [COORD_BITS-1:0] minx_reg, minx_next;
    logic signed [COORD_BITS-1:0] px_reg,   px_next;
    logic signed [COORD_BITS-1:0] py_reg,   py_next;
    logic signed [COORD_BITS-1:0] qx_reg,   qx_next;
    logic signed [COORD_BITS-1:0] qy_reg,   qy_next;
    logic signed [PRD_W-1:0]      prod_a_reg, prod_a_next;
    logic signed [PRD_W-1:0]      prod_b_reg, prod_b_next;
    hull_item_t                   hull_reg,   hull_next;

    // transaction accept and store write
    logic             accept;
    logic             store_wr;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] cur_inc;
    logic [IDX_W-1:0] q_first;
    logic [CNT_W-1:0] hull_cnt_inc;

    // orientation operands: (yi-yp)*(xq-xi) against (xi-xp)*(yq-yi)
    logic signed [DIF_W-1:0] d_yi;
    logic signed [DIF_W-1:0] d_xq;
    logic signed [DIF_W-1:0] d_xi;
    logic signed [DIF_W-1:0] d_yq;

    assign busy     = (ctrl.op != OP_IDLE);
    assign accept   = start && !busy;
    assign store_wr = accept && (count_reg != CNT_W'(MAX_POINTS));

    assign idx_inc      = CNT_W'(idx_reg) + 1'b1;
    assign cur_inc      = CNT_W'(cur_reg) + 1'b1;
    assign q_first      = (cur_inc == count_reg) ? '0 : cur_inc[IDX_W-1:0];
    assign hull_cnt_inc = hull_cnt_reg + 1'b1;

    assign d_yi = {rd_y_reg[COORD_BITS-1], rd_y_reg} - {py_reg[COORD_BITS-1], py_reg};
    assign d_xq = {qx_reg[COORD_BITS-1], qx_reg} - {rd_x_reg[COORD_BITS-1], rd_x_reg};
    assign d_xi = {rd_x_reg[COORD_BITS-1], rd_x_reg} - {px_reg[COORD_BITS-1], px_reg};
    assign d_yq = {qy_reg[COORD_BITS-1], qy_reg} - {rd_y_reg[COORD_BITS-1], rd_y_reg};

    assign status.start_last = accept && point.last_point;
    assign status.more       = (idx_inc < count_reg);
    assign status.term       = (cand_reg == start_reg) || (hull_cnt_inc >= count_reg);

    always_comb
    begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        start_next      = start_reg;
        cur_next        = cur_reg;
        cand_next       = cand_reg;
        idx_next        = idx_reg;
        hull_cnt_next   = hull_cnt_reg;
        hull_valid_next = 1'b0;
        minx_next       = minx_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        prod_a_next     = prod_a_reg;
        prod_b_next     = prod_b_reg;
        hull_next       = hull_reg;

        unique case (ctrl.op)
            OP_IDLE:
            begin
                // load one point; a full store drops it and remembers that
                if (store_wr)
                begin
                    count_next = count_reg + 1'b1;
                end
                else if (accept)
                begin
                    ovf_next = 1'b1;
                end
            end
            OP_LM_INIT:
            begin
                idx_next   = '0;
                start_next = '0;
            end
            OP_READ:
            begin
                // store read is registered, data shows up next step
            end
            OP_LM_CMP:
            begin
                // strict less keeps the first point on ties
                if ((idx_reg == '0) || (rd_x_reg < minx_reg))
                begin
                    minx_next  = rd_x_reg;
                    start_next = idx_reg;
                end
                idx_next = idx_inc[IDX_W-1:0];
            end
            OP_WALK_INIT:
            begin
                cur_next      = start_reg;
                idx_next      = start_reg;
                hull_cnt_next = '0;
            end
            OP_P_LOAD:
            begin
                px_next   = rd_x_reg;
                py_next   = rd_y_reg;
                cand_next = q_first;
                idx_next  = q_first;
            end
            OP_Q_LOAD:
            begin
                qx_next  = rd_x_reg;
                qy_next  = rd_y_reg;
                idx_next = '0;
            end
            OP_MUL:
            begin
                prod_a_next = d_yi * d_xq;
                prod_b_next = d_xi * d_yq;
            end
            OP_S_CMP:
            begin
                // clockwise turn: point i replaces the candidate
                if (prod_a_reg < prod_b_reg)
                begin
                    cand_next = idx_reg;
                    qx_next   = rd_x_reg;
                    qy_next   = rd_y_reg;
                end
                idx_next = idx_inc[IDX_W-1:0];
            end
            OP_EMIT:
            begin
                hull_valid_next          = 1'b1;
                hull_next.hull_x         = to_field(px_reg);
                hull_next.hull_y         = to_field(py_reg);
                hull_next.last_hull_point = status.term;
                hull_next.points_dropped = ovf_reg;
                hull_cnt_next            = hull_cnt_inc;
                cur_next                 = cand_reg;
                idx_next                 = cand_reg;
            end
            OP_FINISH:
            begin
                // next transaction starts a new set
                count_next = '0;
                ovf_next   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            start_reg      <= '0;
            cur_reg        <= '0;
            cand_reg       <= '0;
            idx_reg        <= '0;
            hull_cnt_reg   <= '0;
            hull_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            start_reg      <= start_next;
            cur_reg        <= cur_next;
            cand_reg       <= cand_next;
            idx_reg        <= idx_next;
            hull_cnt_reg   <= hull_cnt_next;
            hull_valid_reg <= hull_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        minx_reg   <= minx_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        hull_reg   <= hull_next;
    end

    // point store
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            mem_x[count_reg[IDX_W-1:0]] <= to_coord(point.point_x);
            mem_y[count_reg[IDX_W-1:0]] <= to_coord(point.point_y);
        end
        rd_x_reg <= mem_x[idx_reg];
        rd_y_reg <= mem_y[idx_reg];
    end

    assign hull_valid = hull_valid_reg;
    assign hull       = hull_reg;

endmodule

// ----- src/chgw_check.sv -----
// port-level checker for the gift-wrap convex hull block, bound to the top level
// depends on chgw_pkg and convex_hull_gift_wrap
`timescale 1ns / 1ps

module chgw_check (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input chgw_pkg::point_item_t point,
    input logic                  hull_valid,
    input chgw_pkg::hull_item_t  hull
);
    import chgw_pkg::*;

    // results only come out during a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        hull_valid |-> busy)
        else $error("result strobe while idle");

    // a point that does not end the set is taken and busy stays low
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !point.last_point) |=> !busy)
        else $error("block stayed busy after a plain point");

    // the last point of a set starts a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && point.last_point) |=> busy)
        else $error("walk did not start after last point");

    // the final hull point closes the walk with no further result
    assert property (@(posedge clk) disable iff (!rst_n)
        (hull_valid && hull.last_hull_point) |=> (!busy && !hull_valid))
        else $error("walk did not end after final hull point");

    // results are never in back-to-back cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        hull_valid |=> !hull_valid)
        else $error("results in adjacent cycles");

endmodule

bind convex_hull_gift_wrap chgw_check u_chgw_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .point      (point),
    .hull_valid (hull_valid),
    .hull       (hull)
);

// ----- dv/tb_convex_hull_gift_wrap.sv -----
// testbench for convex_hull_gift_wrap: feeds point sets through the start/busy port
// and checks every strobed hull point against a gift-wrap predictor of its own
// depends on chgw_pkg and convex_hull_gift_wrap
`timescale 1ns / 1ps

module tb_convex_hull_gift_wrap;
    import chgw_pkg::*;

    localparam int MAX_PTS      = MAX_POINTS_DEF;
    localparam int COORD_W      = COORD_BITS_DEF;
    localparam int RANDOM_ITEMS = 245;
    // quiet drain after the last expected hull point has been seen
    localparam int DRAIN_CYCLES = 400;

    // content styles for random point sets
    typedef enum int {
        SHAPE_WIDE,     // anywhere in the 16 bit range
        SHAPE_BOX,      // tiny box, lots of duplicates and collinear triples
        SHAPE_LINE,     // all points on one line
        SHAPE_EDGE      // hugging the extremes of the coordinate range
    } shape_t;

    // one point transaction waiting to be sent, with its idle gap in front
    typedef struct {
        point_item_t item;
        int          gap;
    } pending_point_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    point_item_t point = '0;
    logic        hull_valid;
    hull_item_t  hull;

    pending_point_t point_queue[$];
    hull_item_t     hull_expected[$];

    // predictor copy of the point store and set status
    longint set_x [MAX_PTS];
    longint set_y [MAX_PTS];
    int     set_count   = 0;
    bit     set_dropped = 1'b0;

    int gap_count      = 0;
    int fail_count     = 0;
    int points_sent    = 0;
    int sets_walked    = 0;
    int overflow_walks = 0;
    int hull_checked   = 0;
    int random_items   = 0;
    hull_item_t got_want;

    convex_hull_gift_wrap dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .point      (point),
        .hull_valid (hull_valid),
        .hull       (hull)
    );

    always #2 clk = ~clk;

    // sign-extend the 16 bit field, then wrap to the stored coordinate width
    function automatic longint wrap_coord(input logic signed [FIELD_W-1:0] raw);
        longint      full;
        logic [63:0] low;
        full = longint'(raw);
        low  = full;
        low  = low & ((64'd1 << COORD_W) - 64'd1);
        if (low[COORD_W-1])
            return longint'(low) - (longint'(1) << COORD_W);
        return longint'(low);
    endfunction

    // orientation test: point i lies clockwise of the ray p -> q
    function automatic bit bends_clockwise(input int p, input int q, input int i);
        longint lhs;
        longint rhs;
        lhs = (set_y[i] - set_y[p]) * (set_x[q] - set_x[i]);
        rhs = (set_x[i] - set_x[p]) * (set_y[q] - set_y[i]);
        return lhs < rhs;
    endfunction

    // store one accepted point; on the last point of a set walk the hull
    // and queue one expected result per hull point
    task automatic predict_hull(input point_item_t it);
        int         first;
        int         cur;
        int         cand;
        int         emitted;
        int         k;
        hull_item_t res;
        if (set_count < MAX_PTS)
        begin
            set_x[set_count] = wrap_coord(it.point_x);
            set_y[set_count] = wrap_coord(it.point_y);
            set_count++;
        end
        else
            set_dropped = 1'b1;
        if (!it.last_point)
            return;

        // leftmost point, lowest index on ties
        first = 0;
        for (k = 1; k < set_count; k++)
            if (set_x[k] < set_x[first])
                first = k;

        cur     = first;
        emitted = 0;
        do
        begin
            res.hull_x          = FIELD_W'(set_x[cur]);
            res.hull_y          = FIELD_W'(set_y[cur]);
            res.points_dropped  = set_dropped;
            res.last_hull_point = 1'b0;
            emitted++;
            cand = (cur + 1) % set_count;
            for (k = 0; k < set_count; k++)
                if (bends_clockwise(cur, cand, k))
                    cand = k;
            cur = cand;
            // back at the start, or cut off after n hull points
            if (cur == first || emitted >= set_count)
                res.last_hull_point = 1'b1;
            hull_expected.push_back(res);
        end
        while (!res.last_hull_point);

        sets_walked++;
        if (set_dropped)
            overflow_walks++;
        set_count   = 0;
        set_dropped = 1'b0;
    endtask

    task automatic add_point(input logic signed [FIELD_W-1:0] x,
                             input logic signed [FIELD_W-1:0] y,
                             input bit last, input int gap);
        pending_point_t p;
        p.item.point_x    = x;
        p.item.point_y    = y;
        p.item.last_point = last;
        p.gap             = gap;
        point_queue.push_back(p);
    endtask

    // one random set of n points, last_point on the final one;
    // a burst set is sent back to back with no idle cycles
    task automatic add_random_set(input int n, input shape_t shape, input bit burst);
        int                        k;
        int                        slope;
        int                        offset;
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        slope  = int'($urandom_range(0, 6)) - 3;
        offset = int'($urandom_range(0, 200)) - 100;
        for (k = 0; k < n; k++)
        begin
            case (shape)
                SHAPE_WIDE:
                begin
                    x = FIELD_W'($urandom);
                    y = FIELD_W'($urandom);
                end
                SHAPE_BOX:
                begin
                    x = FIELD_W'(int'($urandom_range(0, 8)) - 4);
                    y = FIELD_W'(int'($urandom_range(0, 8)) - 4);
                end
                SHAPE_LINE:
                begin
                    x = FIELD_W'(int'($urandom_range(0, 40)) - 20);
                    y = FIELD_W'(x * slope + offset);
                end
                default:
                begin
                    x = $urandom_range(0, 1) ? FIELD_W'(32'h7fff - $urandom_range(0, 3))
                                             : FIELD_W'(32'h8000 + $urandom_range(0, 3));
                    y = $urandom_range(0, 1) ? FIELD_W'(32'h7fff - $urandom_range(0, 3))
                                             : FIELD_W'(32'h8000 + $urandom_range(0, 3));
                end
            endcase
            add_point(x, y, k == n - 1, burst ? 0 : $urandom_range(0, 16));
        end
        random_items += n;
    endtask

    // driver: one point transaction at a time, idle gap drawn per item,
    // start held high until the block takes the point
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            point     <= '0;
            gap_count <= 0;
        end
        else
        begin
            // transaction taken at this edge: predict from the value on the port
            if (start && !busy)
            begin
                predict_hull(point);
                points_sent++;
            end
            // port free: count down the gap, then present the next point
            if (!start || !busy)
            begin
                if (point_queue.size() == 0)
                    start <= 1'b0;
                else if (gap_count < point_queue[0].gap)
                begin
                    gap_count <= gap_count + 1;
                    start     <= 1'b0;
                end
                else
                begin
                    point     <= point_queue[0].item;
                    start     <= 1'b1;
                    gap_count <= 0;
                    void'(point_queue.pop_front());
                end
            end
        end
    end

    // monitor: every strobed hull point is matched to the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && hull_valid)
        begin
            if (hull_expected.size() == 0)
            begin
                $error("hull point with none expected: x=%0d y=%0d",
                       hull.hull_x, hull.hull_y);
                fail_count++;
            end
            else
            begin
                got_want = hull_expected.pop_front();
                if (hull.hull_x !== got_want.hull_x)
                begin
                    $error("hull_x: expected %0d, got %0d", got_want.hull_x, hull.hull_x);
                    fail_count++;
                end
                if (hull.hull_y !== got_want.hull_y)
                begin
                    $error("hull_y: expected %0d, got %0d", got_want.hull_y, hull.hull_y);
                    fail_count++;
                end
                if (hull.last_hull_point !== got_want.last_hull_point)
                begin
                    $error("last_hull_point: expected %0b, got %0b",
                           got_want.last_hull_point, hull.last_hull_point);
                    fail_count++;
                end
                if (hull.points_dropped !== got_want.points_dropped)
                begin
                    $error("points_dropped: expected %0b, got %0b",
                           got_want.points_dropped, hull.points_dropped);
                    fail_count++;
                end
                hull_checked++;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        bit full_done;
        bit overflow_done;
        int n;
        full_done     = 1'b0;
        overflow_done = 1'b0;

        // single point at opposite corners of the range
        add_point(16'sh8000, 16'sh7fff, 1'b1, $urandom_range(0, 16));
        add_point(16'sh7fff, 16'sh8000, 1'b1, $urandom_range(0, 16));
        // extreme square with an inside point
        add_point(16'sh8000, 16'sh8000, 1'b0, $urandom_range(0, 16));
        add_point(16'sh7fff, 16'sh8000, 1'b0, $urandom_range(0, 16));
        add_point(16'sh7fff, 16'sh7fff, 1'b0, $urandom_range(0, 16));
        add_point(16'sh8000, 16'sh7fff, 1'b0, $urandom_range(0, 16));
        add_point(16'sh0000, 16'sh0000, 1'b1, $urandom_range(0, 16));
        // all duplicates: walk is cut off after n hull points
        add_point(5, 5, 1'b0, 0);
        add_point(5, 5, 1'b0, 0);
        add_point(5, 5, 1'b1, 0);
        // collinear points
        add_point(0, 0, 1'b0, $urandom_range(0, 16));
        add_point(1, 1, 1'b0, $urandom_range(0, 16));
        add_point(2, 2, 1'b0, $urandom_range(0, 16));
        add_point(3, 3, 1'b1, $urandom_range(0, 16));
        // tie for leftmost, first index wins
        add_point(-10, 0, 1'b0, $urandom_range(0, 16));
        add_point(-10, 5, 1'b0, $urandom_range(0, 16));
        add_point(0, 0, 1'b1, $urandom_range(0, 16));
        // two points
        add_point(1, 2, 1'b0, 0);
        add_point(-3, 4, 1'b1, 0);
        // plain triangle across the sign boundaries
        add_point(100, -100, 1'b0, $urandom_range(0, 16));
        add_point(-200, 50, 1'b0, $urandom_range(0, 16));
        add_point(300, 300, 1'b1, $urandom_range(0, 16));

        // random sets, mostly small; one exactly full store and one that overflows
        while (random_items < RANDOM_ITEMS)
        begin
            if (!full_done && random_items >= 40)
            begin
                add_random_set(MAX_PTS, SHAPE_WIDE, 1'($urandom_range(0, 1)));
                full_done = 1'b1;
            end
            else if (!overflow_done && random_items >= 160)
            begin
                // extra points past capacity are dropped, the last one carries last_point
                add_random_set(MAX_PTS + $urandom_range(1, 3), SHAPE_BOX, 1'b0);
                overflow_done = 1'b1;
            end
            else
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 32)
                                                : $urandom_range(1, 10);
                add_random_set(n, shape_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // all points taken, all hull points seen, then a quiet drain
        while (point_queue.size() != 0 || start)
            @(posedge clk);
        while (hull_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d points in %0d sets, %0d of them past store capacity",
                 points_sent, sets_walked, overflow_walks);
        $display("compared %0d hull points, %0d mismatches", hull_checked, fail_count);
        if (fail_count == 0 && hull_expected.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
